// ===== rtl/kasd_pkg.sv =====
// ----------------------------------------------------------------------------
// kasd_pkg
// Shared widths, register reset values and configuration register indexes
// for the knob averaging, smoothing and deadband block.
// ----------------------------------------------------------------------------
package kasd_pkg;

  localparam int unsigned CHANNELS_DEF    = 3;
  localparam int unsigned AVG_SAMPLES_DEF = 8;

  localparam int CH_FIELD_W = 2;
  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 16;
  localparam int FRAC_W     = 4;
  localparam int MASK_W     = 3;
  localparam int FS_W       = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  localparam logic [MASK_W-1:0]  ENABLE_MASK_RST = '0;
  localparam logic [FS_W-1:0]    FULL_SCALE_RST  = 12'd3300;
  localparam logic [LEVEL_W-1:0] DEADBAND_RST    = 16'd1584;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK = 2'd0,
    REG_FULL_SCALE  = 2'd1,
    REG_DEADBAND    = 2'd2
  } reg_idx_e;

endpackage

// ===== rtl/knob_average_smooth_deadband_top.sv =====
// ----------------------------------------------------------------------------
// knob_average_smooth_deadband_top
// Per-channel knob conditioning: block average, clamp, exponential smoothing
// and deadband filtering, with channel state held in two small memories.
// ----------------------------------------------------------------------------
// Usage:
// Input beats carry one converter sample for one channel. Samples on a
// disabled channel are accepted and dropped. Every AVG_SAMPLES samples of a
// channel form one averaged reading; the first reading seeds the channel and
// later readings produce an output beat only when the smoothed level moves
// strictly more than the deadband away from the last emitted level.
// The block takes one input beat per cycle while the input is ready. An
// output beat passes stages 2, 3 and 4 and the output register after the
// sample that completes it is accepted. Accumulators sit in one memory read
// at accept and written from stage 1; levels sit in a second memory used
// alike, each with a one-entry bypass for same-channel back-to-back beats.
// Reset clears the configuration to its defaults and marks every channel as
// empty and unseeded. When the receiver stalls, beats that produce no output
// keep flowing; the pipeline holds only when an emitting beat reaches a full
// output register that is not being taken, and then the input is not ready.
// Config writes act at once; the user must make them while idle (unenforced).
// ----------------------------------------------------------------------------
module knob_average_smooth_deadband_top #(
  parameter int unsigned CHANNELS    = kasd_pkg::CHANNELS_DEF,
  parameter int unsigned AVG_SAMPLES = kasd_pkg::AVG_SAMPLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kasd_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [kasd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [kasd_pkg::CH_FIELD_W-1:0] channel_i,
  input  logic [kasd_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                            read_ok_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kasd_pkg::CH_FIELD_W-1:0] out_channel_o,
  output logic [kasd_pkg::LEVEL_W-1:0]    level_o
);
  import kasd_pkg::*;

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W      = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int SUM_W      = $clog2(AVG_SAMPLES * SAMPLE_MAX + 1);
  localparam int ACC_W      = CNT_W + SUM_W;
  localparam int DIV_SH     = SUM_W + 6;
  localparam int MUL_W      = DIV_SH + 1;
  localparam int PROD_W     = SUM_W + MUL_W;
  localparam int MASK_EXT_W = 1 << CH_FIELD_W;
  localparam int LVL_MEM_W  = 2 * LEVEL_W;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((64'd1 << DIV_SH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

  // Configuration registers.
  logic [MASK_W-1:0]  mask_q;
  logic [FS_W-1:0]    fs_q;
  logic [LEVEL_W-1:0] db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= ENABLE_MASK_RST;
      fs_q   <= FULL_SCALE_RST;
      db_q   <= DEADBAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ENABLE_MASK: mask_q <= cfg_wdata_i[MASK_W-1:0];
        REG_FULL_SCALE:  fs_q   <= cfg_wdata_i[FS_W-1:0];
        REG_DEADBAND:    db_q   <= cfg_wdata_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic in_fire;
  logic ch_on;
  logic [MASK_EXT_W-1:0] mask_ext;
  logic [CH_W-1:0] in_ch;

  assign in_ready_o = en;
  assign in_fire    = in_valid_i && en;
  assign mask_ext   = MASK_EXT_W'(mask_q);
  assign in_ch      = CH_W'(channel_i);
  assign ch_on      = mask_ext[channel_i] && (32'(channel_i) < 32'(CHANNELS));

  // Accumulator memory and stage 1.
  logic [ACC_W-1:0] acc_mem [CHANNELS];
  logic [CHANNELS-1:0] acc_vld_q;
  logic [ACC_W-1:0] acc_rd_q;
  logic acc_rdv_q;

  logic s1_vld_q;
  logic [CH_W-1:0] s1_ch_q;
  logic [SAMPLE_W-1:0] s1_smp_q;
  logic afw_vld_q;
  logic [CH_W-1:0] afw_ch_q;
  logic [ACC_W-1:0] afw_data_q;

  logic [ACC_W-1:0] acc_old;
  logic [SUM_W-1:0] sum_n;
  logic [CNT_W:0]   cnt_n;
  logic done;
  logic [ACC_W-1:0] acc_wr;

  always_comb begin
    if (afw_vld_q && afw_ch_q == s1_ch_q) begin
      acc_old = afw_data_q;
    end else if (acc_rdv_q) begin
      acc_old = acc_rd_q;
    end else begin
      acc_old = '0;
    end
    sum_n  = acc_old[SUM_W-1:0] + SUM_W'(s1_smp_q);
    cnt_n  = {1'b0, acc_old[ACC_W-1:SUM_W]} + (CNT_W+1)'(1);
    done   = (cnt_n == (CNT_W+1)'(AVG_SAMPLES));
    acc_wr = done ? '0 : {cnt_n[CNT_W-1:0], sum_n};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_rd_q <= acc_mem[in_ch];
      if (s1_vld_q) begin
        acc_mem[s1_ch_q] <= acc_wr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
      acc_rdv_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      afw_vld_q <= 1'b0;
    end else if (en) begin
      acc_rdv_q <= acc_vld_q[in_ch];
      s1_vld_q  <= in_fire && ch_on;
      afw_vld_q <= s1_vld_q;
      if (s1_vld_q) begin
        acc_vld_q[s1_ch_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ch_q    <= in_ch;
      s1_smp_q   <= read_ok_i ? sample_i : '0;
      afw_ch_q   <= s1_ch_q;
      afw_data_q <= acc_wr;
    end
  end

  // Stage 2: divide by the block length through a reciprocal multiply.
  logic s2_vld_q;
  logic [CH_W-1:0] s2_ch_q;
  logic [SUM_W-1:0] s2_sum_q;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(s2_sum_q) * PROD_W'(DIV_MUL);

  // Stage 3: clamp and scale, read the level memory.
  logic s3_vld_q;
  logic [CH_W-1:0] s3_ch_q;
  logic [SUM_W-1:0] s3_quo_q;
  logic [FS_W-1:0] avg;
  logic [FS_W-1:0] clamped;
  logic [LEVEL_W-1:0] reading;

  assign avg     = s3_quo_q[FS_W-1:0];
  assign clamped = (avg > fs_q) ? fs_q : avg;
  assign reading = LEVEL_W'(clamped) << FRAC_W;

  // Stage 4: smoothing and deadband against the stored levels.
  logic [LVL_MEM_W-1:0] lvl_mem [CHANNELS];
  logic [CHANNELS-1:0] seeded_q;
  logic [LVL_MEM_W-1:0] lvl_rd_q;
  logic lvl_rdv_q;

  logic s4_vld_q;
  logic [CH_W-1:0] s4_ch_q;
  logic [LEVEL_W-1:0] s4_rdg_q;
  logic bfw_vld_q;
  logic [CH_W-1:0] bfw_ch_q;
  logic [LVL_MEM_W-1:0] bfw_data_q;

  logic bfw_hit;
  logic s4_seeded;
  logic [LVL_MEM_W-1:0] lvl_old;
  logic [LEVEL_W-1:0] old_sm;
  logic [LEVEL_W-1:0] old_base;
  logic [LEVEL_W+1:0] ema_sum;
  logic [LEVEL_W-1:0] s4_sm;
  logic [LEVEL_W-1:0] diff;
  logic s4_emit;
  logic [LVL_MEM_W-1:0] lvl_wr;

  always_comb begin
    bfw_hit   = bfw_vld_q && bfw_ch_q == s4_ch_q;
    s4_seeded = bfw_hit || lvl_rdv_q;
    lvl_old   = bfw_hit ? bfw_data_q : lvl_rd_q;
    old_base  = lvl_old[LVL_MEM_W-1:LEVEL_W];
    old_sm    = lvl_old[LEVEL_W-1:0];
    ema_sum   = {2'b00, s4_rdg_q} + {1'b0, old_sm, 1'b0} + {2'b00, old_sm};
    s4_sm     = ema_sum[LEVEL_W+1:2];
    diff      = (s4_sm >= old_base) ? s4_sm - old_base : old_base - s4_sm;
    s4_emit   = s4_vld_q && s4_seeded && (diff > db_q);
    if (!s4_seeded) begin
      lvl_wr = {s4_rdg_q, s4_rdg_q};
    end else if (s4_emit) begin
      lvl_wr = {s4_sm, s4_sm};
    end else begin
      lvl_wr = {old_base, s4_sm};
    end
  end

  assign en = !(s4_emit && out_valid_o && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (en) begin
      lvl_rd_q <= lvl_mem[s3_ch_q];
      if (s4_vld_q) begin
        lvl_mem[s4_ch_q] <= lvl_wr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      seeded_q  <= '0;
      lvl_rdv_q <= 1'b0;
      bfw_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q  <= s1_vld_q && done;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      lvl_rdv_q <= seeded_q[s3_ch_q];
      bfw_vld_q <= s4_vld_q;
      if (s4_vld_q) begin
        seeded_q[s4_ch_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ch_q    <= s1_ch_q;
      s2_sum_q   <= sum_n;
      s3_ch_q    <= s2_ch_q;
      s3_quo_q   <= SUM_W'(prod >> DIV_SH);
      s4_ch_q    <= s3_ch_q;
      s4_rdg_q   <= reading;
      bfw_ch_q   <= s4_ch_q;
      bfw_data_q <= lvl_wr;
    end
  end

  // Output register.
  logic out_vld_q;
  logic [CH_FIELD_W-1:0] out_ch_q;
  logic [LEVEL_W-1:0] out_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s4_emit && en) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_emit && en) begin
      out_ch_q  <= CH_FIELD_W'(s4_ch_q);
      out_lvl_q <= s4_sm;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_channel_o = out_ch_q;
  assign level_o       = out_lvl_q;

  // The reciprocal multiply must give an exact quotient within sample range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q |-> (s3_quo_q >> SAMPLE_W) == '0)
    else $error("block average exceeds the sample range");

  // Emitted levels never pass the scaled sample maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= LEVEL_W'(SAMPLE_MAX << FRAC_W))
    else $error("emitted level out of range");

  // The input is held off only behind a waiting output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked output beat");

  // An emitting beat lands in the output register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_emit && en |=> out_valid_o && level_o == $past(s4_sm))
    else $error("emitted level lost");

endmodule
